[sv/gcd_pkg.sv]
`default_nettype none

package gcd_pkg;

    // Graph size and derived widths
    localparam int MAX_VERTICES = 16;
    localparam int VW           = $clog2(MAX_VERTICES);      // vertex index
    localparam int CW           = $clog2(MAX_VERTICES + 1);  // vertex count
    localparam int VC_W         = 5;                         // vertex_count register
    localparam int PAW          = 3;
    localparam int PDW          = 32;

    // Register map (word index = paddr[2])
    localparam logic REG_VERTEX_COUNT = 1'b0;

    // Command codes
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_CHECK  = 2'd2;

    typedef logic [VW-1:0]           t_vtx;
    typedef logic [CW-1:0]           t_cnt;
    typedef logic [MAX_VERTICES-1:0] t_vset;

    typedef struct packed {
        logic [1:0] command;
        logic [3:0] from_vertex;
        logic [3:0] to_vertex;
    } t_in_item;

    typedef struct packed {
        logic cycle_found;
        logic bad_vertex;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROOT,
        ST_STEP,
        ST_FINISH
    } t_state;

    // Controller -> datapath
    typedef struct packed {
        logic edit_take;   // apply edit (or no-op command) and load its result
        logic chk_init;    // clear walk state for a new check
        logic root_en;     // pick / skip the next root vertex
        logic step_en;     // one neighbor test or pop
        logic fin_load;    // load check result
    } t_dp_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic root_end;    // all roots visited
        logic root_go;     // current root starts a walk
        logic walk_end;    // last frame finished
        logic hit;         // back edge to a vertex on the path
    } t_dp_stat;

endpackage

`default_nettype wire

[sv/graph_cycle_detector.sv]
// Directed-graph cycle detector over a 16 x 16 adjacency bit matrix.
// Input channel (i_in_valid / o_in_ready / i_in_data): one transaction is an
//   insert edge, remove edge, or cycle check. Output channel (o_out_valid /
//   i_out_ready / o_out_data): exactly one result transaction per input.
// APB port: one register, vertex_count, at byte address 0; pready is tied high.
//   Write it only while the block is idle.
// An edit (or unused command) gives its result in the cycle after it is
//   accepted, and the next item can be taken in the following cycle.
// A check runs a depth-first walk, one neighbor test or one stack pop per cycle
//   through a single adjacency row read, plus a root step for each root vertex.
//   A cycle found ends the walk early.
// Reset (synchronous, active low): no edges, vertex_count = 16, no result held.
// Stall: the result sits in an output register until taken; while it waits,
//   a check can still be accepted, an edit is held off.
`default_nettype none

module graph_cycle_detector (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire gcd_pkg::t_in_item         i_in_data,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output gcd_pkg::t_out_item             o_out_data,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [gcd_pkg::PAW-1:0]   paddr,
    input  wire logic [gcd_pkg::PDW-1:0]   pwdata,
    output logic [gcd_pkg::PDW-1:0]        prdata,
    output logic                           pready
);
    import gcd_pkg::*;

    logic [VC_W-1:0] r_vertex_count;
    t_cnt            active_n;
    logic            reg_sel;
    t_dp_cmd         dp_cmd;
    t_dp_stat        dp_stat;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == REG_VERTEX_COUNT);

    // config register; writes outside the map are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= VC_W'(MAX_VERTICES);
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_vertex_count <= pwdata[VC_W-1:0];
        end
    end

    assign prdata = reg_sel ? PDW'(r_vertex_count) : '0;

    // active vertex count saturates at the matrix size
    assign active_n = (r_vertex_count > VC_W'(MAX_VERTICES)) ? CW'(MAX_VERTICES)
                                                            : CW'(r_vertex_count);

    gcd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_cmd    (i_in_data.command),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (dp_cmd),
        .i_stat      (dp_stat)
    );

    gcd_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (dp_cmd),
        .i_in_data  (i_in_data),
        .i_count    (active_n),
        .o_stat     (dp_stat),
        .o_out_data (o_out_data)
    );

endmodule

`default_nettype wire

[sv/gcd_ctrl.sv]
`default_nettype none

module gcd_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic [1:0]        i_in_cmd,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output gcd_pkg::t_dp_cmd       o_cmd,
    input  wire gcd_pkg::t_dp_stat i_stat
);
    import gcd_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;
    logic   is_chk;

    assign out_free = !r_out_valid || i_out_ready;
    assign is_chk   = (i_in_cmd == CMD_CHECK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                // a check does not need the output slot until it finishes
                o_in_ready = is_chk || out_free;
                if (i_in_valid && o_in_ready) begin
                    if (is_chk) begin
                        o_cmd.chk_init = 1'b1;
                        n_state        = ST_ROOT;
                    end else begin
                        o_cmd.edit_take = 1'b1;
                    end
                end
            end
            ST_ROOT: begin
                o_cmd.root_en = 1'b1;
                if (i_stat.root_end) begin
                    n_state = ST_FINISH;
                end else if (i_stat.root_go) begin
                    n_state = ST_STEP;
                end
            end
            ST_STEP: begin
                o_cmd.step_en = 1'b1;
                if (i_stat.hit) begin
                    n_state = ST_FINISH;
                end else if (i_stat.walk_end) begin
                    n_state = ST_ROOT;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    o_cmd.fin_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.edit_take || o_cmd.fin_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

[sv/gcd_dpath.sv]
`default_nettype none

module gcd_dpath (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire gcd_pkg::t_dp_cmd  i_cmd,
    input  wire gcd_pkg::t_in_item i_in_data,
    input  wire gcd_pkg::t_cnt     i_count,
    output gcd_pkg::t_dp_stat      o_stat,
    output gcd_pkg::t_out_item     o_out_data
);
    import gcd_pkg::*;

    // adjacency rows: bit w of row v means edge v->w
    t_vset     r_adj [MAX_VERTICES];
    t_vset     r_done;
    t_vset     r_on_path;
    t_cnt      r_root;
    t_vtx      r_sp;          // saved frames below the current one
    logic      r_found;

    // current frame and saved frames
    t_vtx      r_cur_v;
    t_cnt      r_cur_k;
    t_vtx      r_stk_v [MAX_VERTICES];
    t_cnt      r_stk_k [MAX_VERTICES];

    t_out_item r_out_data;

    t_vtx      root_vtx, k_vtx, from_vtx, to_vtx, sp_m1;
    t_vset     adj_row;
    logic      k_end, edge_bit, can_push, is_edit, bad;

    assign root_vtx = r_root[VW-1:0];
    assign k_vtx    = r_cur_k[VW-1:0];
    assign from_vtx = i_in_data.from_vertex[VW-1:0];
    assign to_vtx   = i_in_data.to_vertex[VW-1:0];
    assign sp_m1    = r_sp - 1'b1;
    assign adj_row  = r_adj[r_cur_v];
    assign k_end    = (r_cur_k >= i_count);
    assign edge_bit = adj_row[k_vtx];
    assign can_push = (r_sp < VW'(MAX_VERTICES - 1));

    assign is_edit  = (i_in_data.command == CMD_INSERT) || (i_in_data.command == CMD_REMOVE);
    assign bad      = (CW'(i_in_data.from_vertex) >= i_count)
                   || (CW'(i_in_data.to_vertex) >= i_count);

    assign o_stat.root_end = (r_root >= i_count);
    assign o_stat.root_go  = !o_stat.root_end && !r_done[root_vtx];
    assign o_stat.walk_end = k_end && (r_sp == '0);
    assign o_stat.hit      = !k_end && edge_bit && r_on_path[k_vtx];

    // edge edits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adj <= '{default: '0};
        end else if (i_cmd.edit_take && is_edit && !bad) begin
            r_adj[from_vtx][to_vtx] <= (i_in_data.command == CMD_INSERT);
        end
    end

    // walk control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root    <= '0;
            r_done    <= '0;
            r_on_path <= '0;
            r_sp      <= '0;
            r_found   <= 1'b0;
        end else if (i_cmd.chk_init) begin
            r_root    <= '0;
            r_done    <= '0;
            r_on_path <= '0;
            r_sp      <= '0;
            r_found   <= 1'b0;
        end else if (i_cmd.root_en && !o_stat.root_end) begin
            r_root <= r_root + 1'b1;
            if (o_stat.root_go) begin
                r_on_path[root_vtx] <= 1'b1;
                r_sp                <= '0;
            end
        end else if (i_cmd.step_en) begin
            if (k_end) begin
                r_on_path[r_cur_v] <= 1'b0;
                r_done[r_cur_v]    <= 1'b1;
                if (r_sp != '0) begin
                    r_sp <= sp_m1;
                end
            end else if (edge_bit) begin
                if (r_on_path[k_vtx]) begin
                    r_found <= 1'b1;
                end else if (!r_done[k_vtx] && can_push) begin
                    r_on_path[k_vtx] <= 1'b1;
                    r_sp             <= r_sp + 1'b1;
                end
            end
        end
    end

    // frame payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.root_en && o_stat.root_go) begin
            r_cur_v <= root_vtx;
            r_cur_k <= '0;
        end else if (i_cmd.step_en) begin
            if (k_end) begin
                if (r_sp != '0) begin
                    r_cur_v <= r_stk_v[sp_m1];
                    r_cur_k <= r_stk_k[sp_m1];
                end
            end else begin
                r_cur_k <= r_cur_k + 1'b1;
                if (edge_bit && !r_on_path[k_vtx] && !r_done[k_vtx] && can_push) begin
                    r_stk_v[r_sp] <= r_cur_v;
                    r_stk_k[r_sp] <= r_cur_k + 1'b1;
                    r_cur_v       <= k_vtx;
                    r_cur_k       <= '0;
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.edit_take) begin
            r_out_data.cycle_found <= 1'b0;
            r_out_data.bad_vertex  <= is_edit && bad;
        end else if (i_cmd.fin_load) begin
            r_out_data.cycle_found <= r_found;
            r_out_data.bad_vertex  <= 1'b0;
        end
    end

    assign o_out_data = r_out_data;

endmodule

`default_nettype wire

[sv/gcd_checker.sv]
`default_nettype none

module gcd_checker (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    input  wire logic                      o_in_ready,
    input  wire gcd_pkg::t_in_item         i_in_data,
    input  wire logic                      o_out_valid,
    input  wire logic                      i_out_ready,
    input  wire gcd_pkg::t_out_item        o_out_data
);
    import gcd_pkg::*;

    // no result survives reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result dropped or changed");

    // a result never flags both a cycle and a bad vertex
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.cycle_found && o_out_data.bad_vertex))
        else $error("cycle_found and bad_vertex both set");

    // an edit answers in the next cycle, never with a cycle
    a_edit_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in_data.command != CMD_CHECK)
        |=> o_out_valid && !o_out_data.cycle_found)
        else $error("edit result missing or wrong");

    // just after a check is accepted, no changed result flags a bad vertex
    a_check_no_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in_data.command == CMD_CHECK)
        |=> !(o_out_valid && $changed(o_out_data) && o_out_data.bad_vertex))
        else $error("check flagged a bad vertex");

endmodule

bind graph_cycle_detector gcd_checker u_gcd_checker (.*);

`default_nettype wire
